FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the LED matrix chain refresher modules.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge while the reset is released.
`define LMCR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("lmcr assertion failed");

// When pre holds, post must hold in the next cycle.
`define LMCR_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lmcr assertion failed");

`endif

FILE: hw/rtl/lmcr_pkg.sv
// Types and constants shared by the LED matrix chain refresher modules.
// No dependencies.
package lmcr_pkg;

  localparam int unsigned COLS_PER_DEV = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned IN_USER_W    = 2;
  localparam int unsigned OUT_DATA_W   = 16;
  localparam logic [15:0] NOOP_WORD    = 16'h0000;

  typedef enum logic [1:0] {
    OP_WRITE_COL = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_REFRESH   = 2'd2,
    OP_BROADCAST = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_READ = 2'd1,
    ST_EMIT = 2'd2
  } back_state_e;

  // A classified item as it travels from the front end to the back end.
  typedef struct packed {
    op_e         op;
    logic        ok;        // column in range (write) or row in range (refresh)
    logic [4:0]  col;
    logic [7:0]  col_bits;
    logic [2:0]  dev;       // target device of a refresh
    logic [2:0]  line;      // bit of the column bytes that forms the row
    logic [15:0] word;      // broadcast command word
  } cmd_t;

endpackage

FILE: hw/rtl/lmcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module lmcr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lmcr_front.sv
// Front end: accepts input words, decodes and range-checks them into commands.
// Depends on lmcr_pkg.
module lmcr_front #(
  parameter int unsigned CHAIN_DEVICES = 4
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [lmcr_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [lmcr_pkg::IN_USER_W-1:0]       s_axis_tuser,
  input  logic                                 full_i,
  output logic                                 push_o,
  output lmcr_pkg::cmd_t                       cmd_o
);
  import lmcr_pkg::*;

  localparam int unsigned STORE_DEPTH = CHAIN_DEVICES * COLS_PER_DEV;

  logic       valid_q, valid_d;
  cmd_t       cmd_q, cmd_d;
  logic       accept;
  logic [4:0] col;
  logic [5:0] row;
  logic [5:0] row_m1;
  logic       col_ok;
  logic       row_ok;

  assign col    = s_axis_tdata[4:0];
  assign row    = s_axis_tdata[18:13];
  assign row_m1 = row - 6'd1;
  assign col_ok = {3'b000, col} < 8'(STORE_DEPTH);
  assign row_ok = (row != 6'd0) && ({2'b00, row} <= 8'(STORE_DEPTH));

  always_comb begin
    cmd_d.op       = op_e'(s_axis_tuser);
    cmd_d.ok       = (op_e'(s_axis_tuser) == OP_REFRESH) ? row_ok : col_ok;
    cmd_d.col      = col;
    cmd_d.col_bits = s_axis_tdata[12:5];
    cmd_d.dev      = row_ok ? row_m1[5:3] : 3'd0;
    cmd_d.line     = row_ok ? row_m1[2:0] : 3'd0;
    // Address byte high, data byte low.
    cmd_d.word     = {s_axis_tdata[26:19], s_axis_tdata[34:27]};
  end

  assign s_axis_tready = !valid_q || !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign push_o        = valid_q && !full_i;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_d;
    end
  end

  assign cmd_o = cmd_q;

endmodule

FILE: hw/rtl/lmcr_queue.sv
// Short command queue between the front end and the back end.
// Depends on lmcr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lmcr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lmcr_pkg::cmd_t cmd_i,
  input  logic           pop_i,
  output lmcr_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import lmcr_pkg::*;

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = PTR_W + 1;

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = count_q == CNT_W'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  `LMCR_ASSERT(a_queue_no_overflow, clk_i, rst_ni, full_o |-> !push_i)
  `LMCR_ASSERT(a_queue_no_underflow, clk_i, rst_ni, pop_i |-> !empty_o)
  `LMCR_ASSERT(a_queue_count_range, clk_i, rst_ni, count_q <= CNT_W'(QUEUE_DEPTH))

endmodule

FILE: hw/rtl/lmcr_back.sv
// Back end: holds the column store, runs commands and drives the word output.
// Depends on lmcr_pkg, lmcr_ram and assert_macros.svh.
`include "assert_macros.svh"

module lmcr_back #(
  parameter int unsigned CHAIN_DEVICES = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            empty_i,
  input  lmcr_pkg::cmd_t                  head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lmcr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lmcr_pkg::*;

  localparam int unsigned STORE_DEPTH = CHAIN_DEVICES * COLS_PER_DEV;
  localparam int unsigned AW          = (CHAIN_DEVICES > 1) ? $clog2(CHAIN_DEVICES) : 1;
  localparam int unsigned IW          = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] LAST_CNT  = AW'(CHAIN_DEVICES - 1);

  back_state_e state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  cmd_t          cmd_q;
  logic [7:0]    rowbyte_q, rowbyte_d;
  logic          out_valid_q, out_valid_d;
  logic [15:0]   out_word_q, out_word_d;
  logic          out_last_q, out_last_d;
  logic [STORE_DEPTH-1:0] valid_q, valid_d;

  logic          load;
  logic          store_clear;
  logic          store_write;
  logic [7:0]    bank_we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata [COLS_PER_DEV];
  logic          is_target;
  logic [15:0]   refresh_word;

  // One RAM bank per column position inside a device; a refresh reads all
  // eight banks at the device address together.
  for (genvar k = 0; k < COLS_PER_DEV; k++) begin : g_bank
    lmcr_ram #(
      .WIDTH (8),
      .DEPTH (CHAIN_DEVICES)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (bank_we[k]),
      .waddr_i (waddr),
      .wdata_i (head_i.col_bits),
      .raddr_i (raddr),
      .rdata_o (rdata[k])
    );
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          if (head_i.op == OP_REFRESH) begin
            state_d = ST_READ;
          end else if (head_i.op == OP_BROADCAST) begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (load && (cnt_q == LAST_CNT)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    pop_o       = 1'b0;
    load        = 1'b0;
    store_clear = 1'b0;
    store_write = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o       = !empty_i;
        store_clear = !empty_i && (head_i.op == OP_CLEAR);
        store_write = !empty_i && (head_i.op == OP_WRITE_COL) && head_i.ok;
      end
      ST_READ: begin
        load = 1'b0;
      end
      ST_EMIT: begin
        load = !out_valid_q || m_axis_tready;
      end
      default: begin
        load = 1'b0;
      end
    endcase
  end

  assign waddr = AW'(head_i.col[4:3]);
  assign raddr = AW'(head_i.dev);

  always_comb begin
    bank_we = '0;
    bank_we[head_i.col[2:0]] = store_write;
  end

  // An entry whose valid bit is clear reads as zero, so a clear only drops
  // the valid bits.
  always_comb begin
    valid_d = valid_q;
    if (store_clear) begin
      valid_d = '0;
    end else if (store_write) begin
      valid_d[IW'(head_i.col)] = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < COLS_PER_DEV; k++) begin
      rowbyte_d[7-k] = rdata[k][cmd_q.line] & valid_q[IW'({cmd_q.dev, 3'(k)})];
    end
  end

  assign is_target    = cmd_q.ok && (5'(cnt_q) == 5'(cmd_q.dev));
  assign refresh_word = {4'b0000, 4'(cmd_q.line) + 4'd1, rowbyte_q};

  always_comb begin
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_word_d  = out_word_q;
    out_last_d  = out_last_q;
    if (pop_o) begin
      cnt_d = '0;
    end
    if (load) begin
      cnt_d       = cnt_q + 1'b1;
      out_valid_d = 1'b1;
      out_last_d  = cnt_q == LAST_CNT;
      if (cmd_q.op == OP_BROADCAST) begin
        out_word_d = cmd_q.word;
      end else begin
        out_word_d = is_target ? refresh_word : NOOP_WORD;
      end
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      valid_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      valid_q     <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= head_i;
    end
    if (state_q == ST_READ) begin
      rowbyte_q <= rowbyte_d;
    end
    out_word_q <= out_word_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_word_q;
  assign m_axis_tlast  = out_last_q;

  `LMCR_ASSERT_NEXT(a_back_read_then_emit, clk_i, rst_ni, state_q == ST_READ, state_q == ST_EMIT)
  `LMCR_ASSERT(a_back_cnt_range, clk_i, rst_ni, (state_q == ST_EMIT) |-> (cnt_q <= LAST_CNT))
  `LMCR_ASSERT_NEXT(a_back_store_still, clk_i, rst_ni, state_q != ST_IDLE, $stable(valid_q))

endmodule

FILE: hw/rtl/led_matrix_chain_refresher.sv
// Top level of the LED matrix chain refresher: front end, command queue, back end.
// Depends on lmcr_pkg, lmcr_front, lmcr_queue and lmcr_back.
//
//  Channel   Dir  Carries
//  s_axis    in   command words: tuser opcode, tdata column/row/command fields
//  m_axis    out  16-bit words for the driver chain, tlast ends each group
//
// A column write or a store clear is done as the back end pops it and emits nothing.
// A refresh goes through the queue pop, the registered store read and one emitted
// word per chain device; a broadcast goes through the queue pop and one emitted word
// per chain device. The output register moves one word per cycle unless the output stalls.
// The front end keeps accepting while the back end works, until the queue and its register fill.
// Reset is asynchronous and active low; it empties the store and the queue.
module led_matrix_chain_refresher #(
  parameter int unsigned CHAIN_DEVICES = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // column_index [4:0], column_bits [12:5], row_number [18:13],
  // command_address [26:19], command_value [34:27], zero fill above
  input  logic [lmcr_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // opcode [1:0]
  input  logic [lmcr_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // serial_word [15:0]
  output logic [lmcr_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);
  import lmcr_pkg::*;

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic push;
  logic pop;
  logic full;
  logic empty;

  lmcr_front #(
    .CHAIN_DEVICES (CHAIN_DEVICES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (front_cmd)
  );

  lmcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .head_o  (head_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  lmcr_back #(
    .CHAIN_DEVICES (CHAIN_DEVICES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (empty),
    .head_i        (head_cmd),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
